### design/segment_nearest_point_assert.svh
// Assertion macros for the segment_nearest_point block.
// Depends on nothing; files that check their own logic include it.
`ifndef SEGMENT_NEAREST_POINT_ASSERT_SVH
`define SEGMENT_NEAREST_POINT_ASSERT_SVH
`ifndef SYNTHESIS
`define SNP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SNP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SNP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SNP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### design/snp_pkg.sv
// Shared types and constants of the segment_nearest_point block.
// Depends on nothing.
package snp_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int PARAM_FRAC = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_Z  = 3'd5;

    localparam logic [63:0] DEGEN_LEN_SQ = 64'd17;
    localparam logic [16:0] PARAM_ONE    = 17'd65536;
    localparam logic [62:0] DIST_MAX     = 63'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CLS_ZERO,
        CLS_ONE,
        CLS_DIV
    } t_cls;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] diff_x;
        logic signed [31:0] diff_y;
        logic signed [31:0] diff_z;
    } t_cfg;

    typedef struct packed {
        t_cls               cls;
        logic [63:0]        dot;
        logic [63:0]        len;
        logic signed [31:0] q_x;
        logic signed [31:0] q_y;
        logic signed [31:0] q_z;
        logic signed [31:0] scale;
    } t_fq;

endpackage

### design/segment_nearest_point.sv
// Top level of the segment_nearest_point block: configuration registers,
// front end, queue and back end. Depends on snp_pkg, snp_front, snp_queue,
// snp_back and segment_nearest_point_assert.svh.

// Nearest point on a fixed 3D segment. Write the start point and the end-minus-start
// vector through the configuration port (indexes 0..5; 6 and 7 are ignored) while the
// block is idle, then stream query points in. Each point yields one result: the clamped
// Q1.16 parameter, the nearest position, the squared distance to it and the parameter
// times the supplied scale, all saturated. The block takes one point per cycle while
// o_in_ready is high; a point passes the front-end steps (subtract, multiply, sum,
// classify), the queue and the back end, whose restoring divider resolves one
// parameter bit per stage before the position, distance and scale are built. The queue lets
// the front end keep accepting while the output is held, until the queue fills.
`include "segment_nearest_point_assert.svh"

module segment_nearest_point #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [snp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [31:0]            i_query_x,
    input  logic signed [31:0]            i_query_y,
    input  logic signed [31:0]            i_query_z,
    input  logic signed [31:0]            i_length_scale,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [16:0]                   o_nearest_param,
    output logic signed [31:0]            o_nearest_x,
    output logic signed [31:0]            o_nearest_y,
    output logic signed [31:0]            o_nearest_z,
    output logic [62:0]                   o_distance_sq,
    output logic signed [31:0]            o_scaled_length
);

    snp_pkg::t_cfg r_cfg;
    snp_pkg::t_fq  fq_item, bq_item;
    logic          fq_valid, fq_ready, bq_valid, bq_ready;

    // Hold the segment; drop writes beyond the last register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                snp_pkg::REG_START_X: r_cfg.start_x <= i_cfg_data;
                snp_pkg::REG_START_Y: r_cfg.start_y <= i_cfg_data;
                snp_pkg::REG_START_Z: r_cfg.start_z <= i_cfg_data;
                snp_pkg::REG_DIFF_X:  r_cfg.diff_x  <= i_cfg_data;
                snp_pkg::REG_DIFF_Y:  r_cfg.diff_y  <= i_cfg_data;
                snp_pkg::REG_DIFF_Z:  r_cfg.diff_z  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Classify each point: degenerate or at or behind the start, past the end, or divide.
    snp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (i_in_valid),
        .o_ready        (o_in_ready),
        .i_query_x      (i_query_x),
        .i_query_y      (i_query_y),
        .i_query_z      (i_query_z),
        .i_length_scale (i_length_scale),
        .o_valid        (fq_valid),
        .i_ready        (fq_ready),
        .o_item         (fq_item)
    );

    // Decouple the two pipelines so each stalls on its own.
    snp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fq_valid),
        .o_ready (fq_ready),
        .i_item  (fq_item),
        .o_valid (bq_valid),
        .i_ready (bq_ready),
        .o_item  (bq_item)
    );

    // Divide, then build position, distance and scaled length.
    snp_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (bq_valid),
        .o_ready         (bq_ready),
        .i_item          (bq_item),
        .o_valid         (o_out_valid),
        .i_ready         (i_out_ready),
        .o_nearest_param (o_nearest_param),
        .o_nearest_x     (o_nearest_x),
        .o_nearest_y     (o_nearest_y),
        .o_nearest_z     (o_nearest_z),
        .o_distance_sq   (o_distance_sq),
        .o_scaled_length (o_scaled_length)
    );

    // The parameter never exceeds one.
    `SNP_ASSERT_IMPL(a_param_range, i_clk, i_rst_n, o_out_valid, o_nearest_param <= snp_pkg::PARAM_ONE)
    // A zero parameter puts the nearest point on the start point.
    `SNP_ASSERT_IMPL(a_zero_start, i_clk, i_rst_n, o_out_valid && (o_nearest_param == 17'd0), (o_nearest_x == r_cfg.start_x) && (o_nearest_y == r_cfg.start_y) && (o_nearest_z == r_cfg.start_z))
    // A front-end word refused by a full queue is still offered next cycle.
    `SNP_ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, fq_valid && !fq_ready, fq_valid)

endmodule

### design/snp_front.sv
// Front end: dot product and squared length, then classification of each point.
// Depends on snp_pkg.
module snp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  snp_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_query_x,
    input  logic signed [31:0] i_query_y,
    input  logic signed [31:0] i_query_z,
    input  logic signed [31:0] i_length_scale,
    output logic               o_valid,
    input  logic               i_ready,
    output snp_pkg::t_fq       o_item
);

    logic               en;
    logic               r_v1, r_v2, r_v3, r_v4;
    logic signed [32:0] r_rel_x, r_rel_y, r_rel_z;
    logic signed [31:0] r1_qx, r1_qy, r1_qz, r1_sc;
    logic signed [64:0] r_p_x, r_p_y, r_p_z;
    logic [63:0]        r_l_x, r_l_y, r_l_z;
    logic signed [31:0] r2_qx, r2_qy, r2_qz, r2_sc;
    logic signed [66:0] r_dot;
    logic [63:0]        r_len;
    logic signed [31:0] r3_qx, r3_qy, r3_qz, r3_sc;
    snp_pkg::t_fq       r_out;
    logic signed [63:0] sq_x, sq_y, sq_z;
    logic               n_zero, n_one;

    assign en      = !r_v4 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v4;
    assign o_item  = r_out;

    assign sq_x = i_cfg.diff_x * i_cfg.diff_x;
    assign sq_y = i_cfg.diff_y * i_cfg.diff_y;
    assign sq_z = i_cfg.diff_z * i_cfg.diff_z;

    // Degenerate segment or point behind the start clamps to 0, past the end to 1.
    assign n_zero = (r_len < snp_pkg::DEGEN_LEN_SQ) || r_dot[66] || (r_dot == '0);
    assign n_one  = r_dot >= $signed({3'b000, r_len});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
        if (en) begin
            r_rel_x <= $signed({i_query_x[31], i_query_x})
                     - $signed({i_cfg.start_x[31], i_cfg.start_x});
            r_rel_y <= $signed({i_query_y[31], i_query_y})
                     - $signed({i_cfg.start_y[31], i_cfg.start_y});
            r_rel_z <= $signed({i_query_z[31], i_query_z})
                     - $signed({i_cfg.start_z[31], i_cfg.start_z});
            r1_qx <= i_query_x;
            r1_qy <= i_query_y;
            r1_qz <= i_query_z;
            r1_sc <= i_length_scale;

            r_p_x <= r_rel_x * i_cfg.diff_x;
            r_p_y <= r_rel_y * i_cfg.diff_y;
            r_p_z <= r_rel_z * i_cfg.diff_z;
            r_l_x <= sq_x;
            r_l_y <= sq_y;
            r_l_z <= sq_z;
            r2_qx <= r1_qx;
            r2_qy <= r1_qy;
            r2_qz <= r1_qz;
            r2_sc <= r1_sc;

            r_dot <= $signed({{2{r_p_x[64]}}, r_p_x}) + $signed({{2{r_p_y[64]}}, r_p_y})
                   + $signed({{2{r_p_z[64]}}, r_p_z});
            r_len <= r_l_x + r_l_y + r_l_z;
            r3_qx <= r2_qx;
            r3_qy <= r2_qy;
            r3_qz <= r2_qz;
            r3_sc <= r2_sc;

            r_out.cls   <= n_zero ? snp_pkg::CLS_ZERO
                         : (n_one ? snp_pkg::CLS_ONE : snp_pkg::CLS_DIV);
            r_out.dot   <= r_dot[63:0];
            r_out.len   <= r_len;
            r_out.q_x   <= r3_qx;
            r_out.q_y   <= r3_qy;
            r_out.q_z   <= r3_qz;
            r_out.scale <= r3_sc;
        end
    end

endmodule

### design/snp_queue.sv
// Short queue between the front end and the back end.
// Depends on snp_pkg.
module snp_queue #(
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  snp_pkg::t_fq i_item,
    output logic         o_valid,
    input  logic         i_ready,
    output snp_pkg::t_fq o_item
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    snp_pkg::t_fq    r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            wr, rd;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_item  = r_mem[r_rp];
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

### design/snp_back.sv
// Back end: pipelined divider for the parameter, then position, distance and scale.
// Depends on snp_pkg.
module snp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  snp_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  snp_pkg::t_fq       i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [16:0]        o_nearest_param,
    output logic signed [31:0] o_nearest_x,
    output logic signed [31:0] o_nearest_y,
    output logic signed [31:0] o_nearest_z,
    output logic [62:0]        o_distance_sq,
    output logic signed [31:0] o_scaled_length
);

    localparam int NF = snp_pkg::PARAM_FRAC;

    typedef struct packed {
        snp_pkg::t_cls      cls;
        logic [63:0]        rem;
        logic [63:0]        len;
        logic [NF-1:0]      quo;
        logic signed [31:0] q_x;
        logic signed [31:0] q_y;
        logic signed [31:0] q_z;
        logic signed [31:0] scale;
    } t_dv;

    function automatic t_dv div_step(input t_dv s);
        t_dv       o;
        logic [64:0] t;
        o = s;
        t = {s.rem, 1'b0};
        if (t >= {1'b0, s.len}) begin
            o.rem = 64'(t - {1'b0, s.len});
            o.quo = {s.quo[NF-2:0], 1'b1};
        end else begin
            o.rem = t[63:0];
            o.quo = {s.quo[NF-2:0], 1'b0};
        end
        return o;
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : a;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
        if (x[34:31] == 4'b0000 || x[34:31] == 4'b1111) begin
            return x[31:0];
        end
        return x[34] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic [33:0] rnd(input logic [48:0] p, input logic s);
        logic [32:0] m;
        m = 33'((p + 49'd32768) >> 16);
        return s ? 34'(-{1'b0, m}) : {1'b0, m};
    endfunction

    function automatic logic [62:0] sq_sat(input logic signed [31:0] n,
                                           input logic signed [31:0] q);
        logic signed [32:0] d;
        logic [32:0]        m;
        logic [63:0]        s;
        d = $signed({n[31], n}) - $signed({q[31], q});
        m = d[32] ? 33'(-d) : d;
        s = m[31:0] * m[31:0];
        return (m[32] || s[63]) ? snp_pkg::DIST_MAX : s[62:0];
    endfunction

    logic               en;
    t_dv                seed;
    t_dv                r_dv  [NF];
    logic               r_dvv [NF];

    logic               r_pv, r_m1v, r_m2v, r_m3v, r_m4v;
    logic [16:0]        r_p_param, r_m1_param, r_m2_param, r_m3_param;
    logic signed [31:0] r_p_qx, r_p_qy, r_p_qz, r_p_sc;
    logic [48:0]        r_m1_px, r_m1_py, r_m1_pz, r_m1_ps;
    logic               r_m1_sx, r_m1_sy, r_m1_sz, r_m1_ss;
    logic signed [31:0] r_m1_qx, r_m1_qy, r_m1_qz;
    logic signed [31:0] r_m2_nx, r_m2_ny, r_m2_nz, r_m2_sl;
    logic signed [31:0] r_m2_qx, r_m2_qy, r_m2_qz;
    logic signed [31:0] r_m3_nx, r_m3_ny, r_m3_nz, r_m3_sl;
    logic [62:0]        r_m3_dx, r_m3_dy, r_m3_dz;
    logic [16:0]        r_o_param;
    logic signed [31:0] r_o_nx, r_o_ny, r_o_nz, r_o_sl;
    logic [62:0]        r_o_dist;
    logic [33:0]        v_x, v_y, v_z, v_s;
    logic [64:0]        dsum;
    logic [16:0]        n_param;

    assign en      = !r_m4v || i_ready;
    assign o_ready = en;
    assign o_valid = r_m4v;

    always_comb begin
        seed.cls   = i_item.cls;
        seed.rem   = i_item.dot;
        seed.len   = i_item.len;
        seed.quo   = '0;
        seed.q_x   = i_item.q_x;
        seed.q_y   = i_item.q_y;
        seed.q_z   = i_item.q_z;
        seed.scale = i_item.scale;
    end

    for (genvar k = 0; k < NF; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[k] <= 1'b0;
            end else if (en) begin
                r_dvv[k] <= (k == 0) ? i_valid : r_dvv[(k == 0) ? 0 : k - 1];
            end
            if (en) begin
                r_dv[k] <= div_step((k == 0) ? seed : r_dv[(k == 0) ? 0 : k - 1]);
            end
        end
    end

    always_comb begin
        case (r_dv[NF-1].cls)
            snp_pkg::CLS_ZERO: n_param = '0;
            snp_pkg::CLS_ONE:  n_param = snp_pkg::PARAM_ONE;
            default:           n_param = {1'b0, r_dv[NF-1].quo};
        endcase
    end

    assign v_x  = rnd(r_m1_px, r_m1_sx);
    assign v_y  = rnd(r_m1_py, r_m1_sy);
    assign v_z  = rnd(r_m1_pz, r_m1_sz);
    assign v_s  = rnd(r_m1_ps, r_m1_ss);
    assign dsum = {2'b00, r_m3_dx} + {2'b00, r_m3_dy} + {2'b00, r_m3_dz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_m1v <= 1'b0;
            r_m2v <= 1'b0;
            r_m3v <= 1'b0;
            r_m4v <= 1'b0;
        end else if (en) begin
            r_pv  <= r_dvv[NF-1];
            r_m1v <= r_pv;
            r_m2v <= r_m1v;
            r_m3v <= r_m2v;
            r_m4v <= r_m3v;
        end
        if (en) begin
            r_p_param <= n_param;
            r_p_qx    <= r_dv[NF-1].q_x;
            r_p_qy    <= r_dv[NF-1].q_y;
            r_p_qz    <= r_dv[NF-1].q_z;
            r_p_sc    <= r_dv[NF-1].scale;

            r_m1_px    <= mag32(i_cfg.diff_x) * r_p_param;
            r_m1_py    <= mag32(i_cfg.diff_y) * r_p_param;
            r_m1_pz    <= mag32(i_cfg.diff_z) * r_p_param;
            r_m1_ps    <= mag32(r_p_sc) * r_p_param;
            r_m1_sx    <= i_cfg.diff_x[31];
            r_m1_sy    <= i_cfg.diff_y[31];
            r_m1_sz    <= i_cfg.diff_z[31];
            r_m1_ss    <= r_p_sc[31];
            r_m1_param <= r_p_param;
            r_m1_qx    <= r_p_qx;
            r_m1_qy    <= r_p_qy;
            r_m1_qz    <= r_p_qz;

            r_m2_nx    <= sat32($signed({{3{i_cfg.start_x[31]}}, i_cfg.start_x})
                              + $signed({v_x[33], v_x}));
            r_m2_ny    <= sat32($signed({{3{i_cfg.start_y[31]}}, i_cfg.start_y})
                              + $signed({v_y[33], v_y}));
            r_m2_nz    <= sat32($signed({{3{i_cfg.start_z[31]}}, i_cfg.start_z})
                              + $signed({v_z[33], v_z}));
            r_m2_sl    <= sat32($signed({v_s[33], v_s}));
            r_m2_param <= r_m1_param;
            r_m2_qx    <= r_m1_qx;
            r_m2_qy    <= r_m1_qy;
            r_m2_qz    <= r_m1_qz;

            r_m3_dx    <= sq_sat(r_m2_nx, r_m2_qx);
            r_m3_dy    <= sq_sat(r_m2_ny, r_m2_qy);
            r_m3_dz    <= sq_sat(r_m2_nz, r_m2_qz);
            r_m3_nx    <= r_m2_nx;
            r_m3_ny    <= r_m2_ny;
            r_m3_nz    <= r_m2_nz;
            r_m3_sl    <= r_m2_sl;
            r_m3_param <= r_m2_param;

            r_o_dist  <= (dsum[64:63] != 2'b00) ? snp_pkg::DIST_MAX : dsum[62:0];
            r_o_nx    <= r_m3_nx;
            r_o_ny    <= r_m3_ny;
            r_o_nz    <= r_m3_nz;
            r_o_sl    <= r_m3_sl;
            r_o_param <= r_m3_param;
        end
    end

    assign o_nearest_param = r_o_param;
    assign o_nearest_x     = r_o_nx;
    assign o_nearest_y     = r_o_ny;
    assign o_nearest_z     = r_o_nz;
    assign o_distance_sq   = r_o_dist;
    assign o_scaled_length = r_o_sl;

endmodule

### tb/sv/segment_nearest_point_tb.sv
// Testbench for segment_nearest_point: drives query words, predicts each result with an
// integer model of the projection and compares every output field. Depends on snp_pkg
// and the segment_nearest_point RTL.
module segment_nearest_point_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [16:0]        param;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic [62:0]        dist_sq;
        logic signed [31:0] scaled;
    } t_nearest;

    // Holds the segment copy and the queue of predicted nearest-point words.
    class nearest_scoreboard;
        logic signed [31:0] seg[6];
        t_nearest           pending[$];
        int                 errors;

        function void write_reg(logic [snp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx <= snp_pkg::REG_DIFF_Z) seg[idx] = val;
        endfunction

        static function longint round_param(longint a, longint p);
            longint m;
            m = ((a < 0 ? -a : a) * p + 32768) >>> 16;
            return a < 0 ? -m : m;
        endfunction

        static function longint clip32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        static function logic [63:0] square_clip(longint d);
            logic [63:0] m;
            m = d < 0 ? -d : d;
            if (m > 64'hFFFF_FFFF) return {1'b0, snp_pkg::DIST_MAX};
            m = m * m;
            return m > {1'b0, snp_pkg::DIST_MAX} ? {1'b0, snp_pkg::DIST_MAX} : m;
        endfunction

        function void note_query(logic signed [31:0] qx, qy, qz, sc);
            logic signed [127:0] dot;
            logic [127:0]        len, num, quo;
            logic signed [31:0]  q[3];
            logic [63:0]         acc, sq;
            longint              near[3];
            logic [16:0]         p;
            t_nearest            r;
            q[0] = qx; q[1] = qy; q[2] = qz;
            dot = 0; len = 0;
            for (int i = 0; i < 3; i++) begin
                dot += (longint'(q[i]) - longint'(seg[i])) * 128'(signed'(seg[3+i]));
                len += 128'(longint'(seg[3+i]) * longint'(seg[3+i]));
            end
            if (len < 17 || dot <= 0) p = 0;
            else if (dot >= signed'(len)) p = snp_pkg::PARAM_ONE;
            else begin
                num = dot;
                quo = (num << 16) / len;
                p = quo[16:0];
            end
            acc = 0;
            for (int i = 0; i < 3; i++) begin
                near[i] = clip32(longint'(seg[i]) + round_param(seg[3+i], p));
                sq = square_clip(near[i] - longint'(q[i]));
                acc = acc + sq;
                if (acc > {1'b0, snp_pkg::DIST_MAX}) acc = {1'b0, snp_pkg::DIST_MAX};
            end
            r.param = p;
            r.nx = 32'(near[0]); r.ny = 32'(near[1]); r.nz = 32'(near[2]);
            r.dist_sq = acc[62:0];
            r.scaled = 32'(clip32(round_param(sc, p)));
            pending.push_back(r);
        endfunction

        function void check_result(t_nearest got);
            t_nearest want;
            if (pending.size() == 0) begin
                report_mismatch("result with no pending query");
                return;
            end
            want = pending.pop_front();
            if (got.param !== want.param)
                report_mismatch($sformatf("param %0d want %0d", got.param, want.param));
            if (got.nx !== want.nx) report_mismatch($sformatf("x %0d want %0d", got.nx, want.nx));
            if (got.ny !== want.ny) report_mismatch($sformatf("y %0d want %0d", got.ny, want.ny));
            if (got.nz !== want.nz) report_mismatch($sformatf("z %0d want %0d", got.nz, want.nz));
            if (got.dist_sq !== want.dist_sq)
                report_mismatch($sformatf("dist %0d want %0d", got.dist_sq, want.dist_sq));
            if (got.scaled !== want.scaled)
                report_mismatch($sformatf("scaled %0d want %0d", got.scaled, want.scaled));
        endfunction

        function void report_mismatch(string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endfunction
    endclass

    logic                          i_clk = 0, i_rst_n = 0;
    logic                          i_cfg_we = 0;
    logic [snp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data = '0;
    logic                          i_in_valid = 0, i_out_ready = 0;
    logic signed [31:0]            i_query_x = 0, i_query_y = 0, i_query_z = 0;
    logic signed [31:0]            i_length_scale = 0;
    logic                          o_in_ready, o_out_valid;
    logic [16:0]                   o_nearest_param;
    logic signed [31:0]            o_nearest_x, o_nearest_y, o_nearest_z, o_scaled_length;
    logic [62:0]                   o_distance_sq;

    segment_nearest_point u_dut (.*);

    always #4 i_clk = ~i_clk;

    nearest_scoreboard sb = new();
    int  send_idle, recv_stall, cycles, queries, results;

    // Receiver: check every accepted result word, stall at random.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result({o_nearest_param, o_nearest_x, o_nearest_y, o_nearest_z,
                             o_distance_sq, o_scaled_length});
            results <= results + 1;
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        if (cycles > 2000000) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [31:0] edge_word();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom_range(64) - 32;
            default: return $urandom;
        endcase
    endfunction

    // Write one register; only called while the pipeline is empty. The caller drops
    // the write enable once the last write of a group is done.
    task automatic write_reg(logic [snp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
    endtask

    // Offer one query word and hold it until accepted; idle first at random.
    task automatic send_query(logic signed [31:0] qx, qy, qz, sc);
        if ($urandom_range(99) < send_idle) begin
            i_in_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle) @(posedge i_clk);
        end
        i_in_valid <= 1; i_query_x <= qx; i_query_y <= qy; i_query_z <= qz;
        i_length_scale <= sc;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_query(qx, qy, qz, sc);
        queries++;
    endtask

    // Drop valid and wait for the pipeline to drain before touching the registers.
    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_segment(logic [31:0] sx, sy, sz, dx, dy, dz);
        write_reg(snp_pkg::REG_START_X, sx);
        write_reg(snp_pkg::REG_START_Y, sy);
        write_reg(snp_pkg::REG_START_Z, sz);
        write_reg(snp_pkg::REG_DIFF_X, dx);
        write_reg(snp_pkg::REG_DIFF_Y, dy);
        write_reg(snp_pkg::REG_DIFF_Z, dz);
        i_cfg_we <= 0;
    endtask

    // Query near the segment so the parameter often lands strictly inside 0..1.
    task automatic near_query();
        logic signed [31:0] q[3];
        longint t;
        t = longint'($urandom_range(1400)) - 200;
        for (int i = 0; i < 3; i++)
            q[i] = 32'(sb.clip32(longint'(sb.seg[i]) + longint'(sb.seg[3+i]) * t / 1000
                                 + longint'($urandom_range(8192)) - 4096));
        send_query(q[0], q[1], q[2], $urandom);
    endtask

    initial begin
        send_idle = 0; recv_stall = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset segment is degenerate, then extremes and clamps.
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        drain();
        set_segment(0, 0, 0, 32'd4096, 0, 0);
        send_query(32'd2048, 0, 0, 32'd4096);          // inside
        send_query(-32'd4096, 0, 0, 32'd4096);         // before start
        send_query(32'd8192, 7, 0, -32'd4096);         // past end
        send_query(32'd4096, 0, 0, 32'h8000_0000);     // exactly the end
        send_query(0, 32'd4096, 0, 32'd1);             // perpendicular
        send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        set_segment(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_query(0, 0, 0, 32'h7FFF_FFFF);
        send_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, -32'd1);
        send_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd4096);
        drain();
        set_segment(5, -3, 9, 4, 0, 0);                // length squared 16: degenerate
        send_query(32'd100, 0, 0, 32'd4096);
        drain();
        set_segment(5, -3, 9, 4, 1, 0);                // length squared 17: just usable
        send_query(32'd100, 0, 0, 32'd4096);
        send_query(32'd7, -3, 9, 32'd4096);
        drain();
        write_reg(3'd6, 32'hFFFF_FFFF);                // ignored indexes
        write_reg(3'd7, 32'h1234_5678);
        i_cfg_we <= 0;
        send_query(32'd7, -3, 9, 32'd4096);
        drain();

        // Random: four idling phases, new segment every 58 words.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle  = (ph == 1) ? 48 : (ph == 3) ? 18 : 0;
            recv_stall = (ph == 2) ? 48 : (ph == 3) ? 18 : 0;
            for (int blk = 0; blk < 8; blk++) begin
                set_segment(edge_word(), edge_word(), edge_word(),
                            ($urandom_range(3) == 0) ? edge_word() : $urandom_range(1 << 20),
                            ($urandom_range(3) == 0) ? edge_word() : -$urandom_range(1 << 20),
                            ($urandom_range(3) == 0) ? edge_word() : $urandom);
                for (int k = 0; k < 58; k++) begin
                    if ($urandom_range(3) != 0) near_query();
                    else send_query(edge_word(), edge_word(), edge_word(), edge_word());
                end
                drain();
            end
        end

        $display("Ran %0d query words through %0d segment settings and four idling phases;",
                 queries, 37);
        $display("%0d results checked field by field.", results);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
